>>> sv/ffpa_pkg.sv
package ffpa_pkg;

    // Region geometry
    localparam int PAGE_BYTES = 256;
    localparam int NUM_PAGES  = 256;
    localparam int ADDR_W     = 16;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int NEED_W     = ADDR_W + 1 - PAGE_SHIFT;

    // Chain geometry: each cell owns GROUP consecutive pages
    localparam int GROUP     = 8;
    localparam int SUB_W     = $clog2(GROUP);
    localparam int NUM_CELLS = NUM_PAGES / GROUP;
    localparam int CELL_W    = $clog2(NUM_CELLS);

    // Operation and status codes
    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_FREE   = 1'b1;
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    typedef enum logic [1:0] {
        WAVE_SCAN,
        WAVE_SET,
        WAVE_CLEAR
    } wave_mode_t;

    // Token that travels down the cell chain, one cell per cycle
    typedef struct packed {
        logic              valid;
        wave_mode_t        mode;
        logic              hit;
        logic [PAGE_W-1:0] need;
        logic [PAGE_W-1:0] cnt;
        logic [PAGE_W-1:0] start;
    } wave_t;

    // Number of pages covering a byte count, rounded up
    function automatic logic [NEED_W-1:0] pages_for(input logic [ADDR_W-1:0] bytes);
        logic [ADDR_W:0] sum;
        sum = {1'b0, bytes} + (ADDR_W+1)'(PAGE_BYTES - 1);
        return NEED_W'(sum >> PAGE_SHIFT);
    endfunction

endpackage

>>> sv/ffpa_req_if.sv
interface ffpa_req_if import ffpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] req_bytes;
    logic [ADDR_W-1:0] free_addr;

    modport source (output valid, output op, output req_bytes, output free_addr, input ready);
    modport sink   (input valid, input op, input req_bytes, input free_addr, output ready);
endinterface

>>> sv/ffpa_rsp_if.sv
interface ffpa_rsp_if import ffpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic [ADDR_W-1:0] alloc_addr;
    logic [ADDR_W-1:0] freed_bytes;

    modport source (output valid, output status, output alloc_addr, output freed_bytes,
                    input ready);
    modport sink   (input valid, input status, input alloc_addr, input freed_bytes,
                    output ready);
endinterface

>>> sv/ffpa_cell.sv
module ffpa_cell import ffpa_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CELL_W-1:0] cell_idx,
    input  wave_t             tok_in,
    output wave_t             tok_out
);

    logic [GROUP-1:0] used_reg;
    logic [GROUP-1:0] used_next;
    logic [GROUP-1:0] base_reg;
    logic [GROUP-1:0] base_next;
    wave_t            tok_out_reg;
    wave_t            tok_next;

    // Walk the token over this cell's pages, lowest page first
    always_comb
    begin
        logic [PAGE_W-1:0] page;
        wave_t             t;
        page      = '0;
        t         = tok_in;
        used_next = used_reg;
        base_next = base_reg;
        if (tok_in.valid)
        begin
            for (int j = 0; j < GROUP; j++)
            begin
                page = {cell_idx, SUB_W'(j)};
                case (t.mode)
                    WAVE_SCAN:
                    begin
                        // page 0 is reserved and always counts as used
                        if (!t.hit)
                        begin
                            if (!used_reg[j] && page != '0)
                            begin
                                if (t.cnt == '0)
                                    t.start = page;
                                t.cnt = t.cnt + 1'b1;
                                if (t.cnt == t.need)
                                    t.hit = 1'b1;
                            end
                            else
                            begin
                                t.cnt = '0;
                            end
                        end
                    end
                    WAVE_SET:
                    begin
                        if (page >= t.start && t.cnt != '0)
                        begin
                            used_next[j] = 1'b1;
                            base_next[j] = (page == t.start);
                            t.cnt        = t.cnt - 1'b1;
                        end
                    end
                    WAVE_CLEAR:
                    begin
                        // base check at the target page, abort on mismatch
                        if (page == t.start)
                        begin
                            t.hit = used_reg[j] && base_reg[j];
                            if (!t.hit)
                                t.cnt = '0;
                        end
                        if (t.hit && page >= t.start && t.cnt != '0)
                        begin
                            used_next[j] = 1'b0;
                            t.cnt        = t.cnt - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        tok_next = t;
    end

    // Page flags and outgoing token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            base_reg    <= '0;
            tok_out_reg <= '0;
        end
        else
        begin
            used_reg    <= used_next;
            base_reg    <= base_next;
            tok_out_reg <= tok_next;
        end
    end

    assign tok_out = tok_out_reg;

    // Reserved page is never claimed by a set wave
    a_page0_free_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_idx == '0) |-> !used_reg[0])
        else $error("reserved page flag was set");

    // Scan run length never passes the requested length
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_out_reg.valid && tok_out_reg.mode == WAVE_SCAN)
            |-> (tok_out_reg.cnt <= tok_out_reg.need))
        else $error("scan run exceeded need");

    // Token moves on next cycle with its mode intact
    a_token_moves: assert property (@(posedge clk) disable iff (!rst_n)
        tok_in.valid |=> (tok_out_reg.valid && tok_out_reg.mode == $past(tok_in.mode)))
        else $error("token lost or altered in cell");

    // A set wave only adds used pages
    a_set_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_in.valid && tok_in.mode == WAVE_SET)
            |=> ((used_reg & $past(used_reg)) == $past(used_reg)))
        else $error("set wave released a page");

endmodule

>>> sv/ffpa_ctrl.sv
module ffpa_ctrl import ffpa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    ffpa_req_if.sink    req,
    ffpa_rsp_if.source  rsp,
    output wave_t       launch,
    input  wave_t       exit_tok
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_READ,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    wave_t             launch_reg;
    wave_t             launch_next;
    logic [ADDR_W-1:0] bytes_reg;
    logic [ADDR_W-1:0] bytes_next;
    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] page_next;
    logic              res_status_reg;
    logic              res_status_next;
    logic [ADDR_W-1:0] res_addr_reg;
    logic [ADDR_W-1:0] res_addr_next;
    logic [ADDR_W-1:0] res_freed_reg;
    logic [ADDR_W-1:0] res_freed_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic              rsp_status_reg;
    logic              rsp_status_next;
    logic [ADDR_W-1:0] rsp_addr_reg;
    logic [ADDR_W-1:0] rsp_addr_next;
    logic [ADDR_W-1:0] rsp_freed_reg;
    logic [ADDR_W-1:0] rsp_freed_next;

    // Recorded request size, written at the base page of each allocation
    logic [ADDR_W-1:0] size_mem [NUM_PAGES];
    logic [ADDR_W-1:0] size_q_reg;
    logic [PAGE_W-1:0] rd_page;
    logic              mem_we;

    logic [NEED_W-1:0]        alloc_need;
    logic [NEED_W-1:0]        free_need;
    logic [ADDR_W-PAGE_SHIFT-1:0] free_page_wide;
    logic                     free_aligned;

    assign alloc_need     = pages_for(req.req_bytes);
    assign free_need      = pages_for(size_q_reg);
    assign free_page_wide = req.free_addr[ADDR_W-1:PAGE_SHIFT];
    assign free_aligned   = (req.free_addr & ADDR_W'(PAGE_BYTES - 1)) == '0;
    assign rd_page        = PAGE_W'(free_page_wide);
    assign mem_we         = (state_reg == ST_SCAN) && exit_tok.valid && exit_tok.hit;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            size_mem[exit_tok.start] <= bytes_reg;
        // size is captured at the accepting edge and held for the whole free
        if (state_reg == ST_IDLE)
            size_q_reg <= size_mem[rd_page];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        launch_next     = launch_reg;
        launch_next.valid = 1'b0;
        bytes_next      = bytes_reg;
        page_next       = page_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_freed_next  = res_freed_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_freed_next  = rsp_freed_reg;

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next = STAT_FAIL;
                    res_addr_next   = '0;
                    res_freed_next  = '0;
                    if (req.op == OP_ALLOC)
                    begin
                        bytes_next = req.req_bytes;
                        if (alloc_need == '0 || int'(alloc_need) > NUM_PAGES - 1)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            launch_next.valid = 1'b1;
                            launch_next.mode  = WAVE_SCAN;
                            launch_next.hit   = 1'b0;
                            launch_next.need  = PAGE_W'(alloc_need);
                            launch_next.cnt   = '0;
                            launch_next.start = '0;
                            state_next        = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (!free_aligned || free_page_wide == '0
                            || int'(free_page_wide) >= NUM_PAGES)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            page_next  = rd_page;
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (exit_tok.valid)
                begin
                    if (exit_tok.hit)
                    begin
                        launch_next.valid = 1'b1;
                        launch_next.mode  = WAVE_SET;
                        launch_next.hit   = 1'b0;
                        launch_next.need  = exit_tok.need;
                        launch_next.cnt   = exit_tok.need;
                        launch_next.start = exit_tok.start;
                        res_addr_next     = ADDR_W'(32'(exit_tok.start) << PAGE_SHIFT);
                        state_next        = ST_MARK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MARK:
            begin
                if (exit_tok.valid)
                begin
                    res_status_next = STAT_OK;
                    state_next      = ST_DONE;
                end
            end
            ST_READ:
            begin
                launch_next.valid = 1'b1;
                launch_next.mode  = WAVE_CLEAR;
                launch_next.hit   = 1'b0;
                launch_next.need  = PAGE_W'(free_need);
                launch_next.cnt   = PAGE_W'(free_need);
                launch_next.start = page_reg;
                state_next        = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (exit_tok.valid)
                begin
                    if (exit_tok.hit)
                    begin
                        res_status_next = STAT_OK;
                        res_freed_next  = size_q_reg;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hand the result to the output register once it is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_addr_next   = res_addr_reg;
                    rsp_freed_next  = res_freed_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            launch_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            launch_reg     <= launch_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bytes_reg      <= bytes_next;
        page_reg       <= page_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_freed_reg  <= res_freed_next;
        rsp_status_reg <= rsp_status_next;
        rsp_addr_reg   <= rsp_addr_next;
        rsp_freed_reg  <= rsp_freed_next;
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.alloc_addr  = rsp_addr_reg;
    assign rsp.freed_bytes = rsp_freed_reg;
    assign launch          = launch_reg;

    // A token leaves the chain only while a wave is awaited
    a_exit_expected: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok.valid
            |-> (state_reg == ST_SCAN || state_reg == ST_MARK || state_reg == ST_CLEAR))
        else $error("unexpected token at chain end");

    // Returning token matches the wave being waited on
    a_exit_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (exit_tok.valid && state_reg == ST_SCAN) |-> (exit_tok.mode == WAVE_SCAN))
        else $error("scan state got a non-scan token");

    // A single token per launch
    a_single_launch: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg.valid |=> !launch_reg.valid)
        else $error("back-to-back launch");

    // Failed transactions carry zero address and size
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg == STAT_FAIL)
            |-> (rsp_addr_reg == '0 && rsp_freed_reg == '0))
        else $error("failure result with nonzero payload");

endmodule

>>> sv/first_fit_page_allocator.sv
// Allocate runs a scan wave, then a mark wave, and ends after the scan when it finds no run;
// free reads the stored size, then runs a clear wave; requests rejected up front skip the
// waves and go straight to the result.
// One transaction at a time; each wave crosses one cell (8 pages) per cycle.
// The next request is taken as soon as the result sits in the output register.
// Reset (async, active low) clears all page flags; page 0 stays reserved, no clearing pass.
module first_fit_page_allocator import ffpa_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    ffpa_req_if.sink   req,
    ffpa_rsp_if.source rsp
);

    wave_t chain [NUM_CELLS+1];

    // Sequencer launches waves into cell 0 and collects them from the last cell
    ffpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .launch   (chain[0]),
        .exit_tok (chain[NUM_CELLS])
    );

    // Row of page cells
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        ffpa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (CELL_W'(i)),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

endmodule

>>> tb/testbench.sv
module testbench;
    import ffpa_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 150;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] req_bytes;
        logic [ADDR_W-1:0] free_addr;
    } request_t;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] alloc_addr;
        logic [ADDR_W-1:0] freed_bytes;
    } outcome_t;

    logic clk;
    logic rst_n;

    ffpa_req_if req_ch ();
    ffpa_rsp_if rsp_ch ();

    first_fit_page_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the page map
    bit                page_busy [NUM_PAGES];
    logic [PAGE_W-1:0] page_base [NUM_PAGES];
    logic [ADDR_W-1:0] page_len  [NUM_PAGES];

    outcome_t queued_outcomes [$];

    int mismatch_count = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int rx_hold_request = 0;
    int stall_cycles   = 0;
    int sent_count     = 0;
    int allocs_granted = 0;
    int allocs_refused = 0;
    int frees_done     = 0;
    int frees_refused  = 0;

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Applies one request to the shadow page map and returns what the block should answer
    function automatic outcome_t apply_to_page_map(input request_t rq);
        outcome_t res;
        int       need;
        int       run;
        int       start;
        int       page;
        int       count;
        bit       found;
        res.status      = STAT_FAIL;
        res.alloc_addr  = '0;
        res.freed_bytes = '0;
        if (rq.op == OP_ALLOC)
        begin
            need  = (int'(rq.req_bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
            run   = 0;
            start = 0;
            found = 1'b0;
            if (need != 0 && need <= NUM_PAGES - 1)
            begin
                // first fit, page 0 never taken
                for (int i = 1; i < NUM_PAGES && !found; i++)
                begin
                    if (!page_busy[i])
                    begin
                        if (run == 0)
                            start = i;
                        run++;
                        if (run == need)
                            found = 1'b1;
                    end
                    else
                        run = 0;
                end
            end
            if (found)
            begin
                for (int i = start; i < start + need; i++)
                begin
                    page_busy[i] = 1'b1;
                    page_base[i] = PAGE_W'(start);
                    page_len[i]  = rq.req_bytes;
                end
                res.status     = STAT_OK;
                res.alloc_addr = ADDR_W'(start * PAGE_BYTES);
            end
        end
        else
        begin
            page = int'(rq.free_addr) / PAGE_BYTES;
            if (int'(rq.free_addr) % PAGE_BYTES == 0 && page != 0 && page < NUM_PAGES
                && page_busy[page] && int'(page_base[page]) == page)
            begin
                count = (int'(page_len[page]) + PAGE_BYTES - 1) / PAGE_BYTES;
                for (int i = 0; i < count && page + i < NUM_PAGES; i++)
                    page_busy[page + i] = 1'b0;
                res.status      = STAT_OK;
                res.freed_bytes = page_len[page];
            end
        end
        return res;
    endfunction

    task automatic check_field(input string what, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Offer one request, wait for the handshake, then record its predicted outcome
    task automatic send_request(input request_t rq);
        outcome_t res;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        req_ch.valid     <= 1'b1;
        req_ch.op        <= rq.op;
        req_ch.req_bytes <= rq.req_bytes;
        req_ch.free_addr <= rq.free_addr;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        res = apply_to_page_map(rq);
        queued_outcomes.push_back(res);
        sent_count++;
        if (rq.op == OP_ALLOC)
        begin
            if (res.status == STAT_OK)
                allocs_granted++;
            else
                allocs_refused++;
        end
        else if (res.status == STAT_OK)
            frees_done++;
        else
            frees_refused++;
    endtask

    task automatic send_alloc(input logic [ADDR_W-1:0] bytes);
        request_t rq;
        rq.op        = OP_ALLOC;
        rq.req_bytes = bytes;
        rq.free_addr = ADDR_W'($urandom);
        send_request(rq);
    endtask

    task automatic send_free(input logic [ADDR_W-1:0] addr);
        request_t rq;
        rq.op        = OP_FREE;
        rq.req_bytes = ADDR_W'($urandom);
        rq.free_addr = addr;
        send_request(rq);
    endtask

    // Free every live allocation, lowest base first
    task automatic release_all_blocks();
        int bases [$];
        for (int p = 1; p < NUM_PAGES; p++)
            if (page_busy[p] && int'(page_base[p]) == p)
                bases.push_back(p);
        foreach (bases[k])
            send_free(ADDR_W'(bases[k] * PAGE_BYTES));
    endtask

    // Stop offering and wait until every result is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (queued_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Size extremes, rejected frees and a full region
    task automatic test_directed_cases();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        send_alloc(16'd0);
        send_alloc(16'd1);
        send_alloc(16'd256);
        send_alloc(16'd257);
        send_alloc(16'd1000);
        send_alloc(16'hFFFF);
        send_alloc(16'd65280);
        send_free(16'h0000);
        send_free(16'h0101);
        send_free(16'hFFFF);
        send_free(16'h0600);
        send_free(16'h0300);
        send_free(16'h0100);
        send_free(16'h0100);
        send_free(16'h2000);
        release_all_blocks();
        // whole region in one run, then a run ending on the last page
        send_alloc(16'd65280);
        send_alloc(16'd1);
        send_free(16'h0100);
        send_alloc(16'd65024);
        send_alloc(16'd1);
        send_free(16'hFF00);
        release_all_blocks();
        wait_drained();
    endtask

    // Mostly frees of live blocks and small allocations, plus malformed requests
    task automatic test_random_traffic(input int items, input int tx_pct, input int rx_pct);
        request_t rq;
        int       bases [$];
        int       used;
        int       pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (items)
        begin
            bases.delete();
            used = 0;
            for (int p = 1; p < NUM_PAGES; p++)
            begin
                used += page_busy[p];
                if (page_busy[p] && int'(page_base[p]) == p)
                    bases.push_back(p);
            end
            rq.req_bytes = ADDR_W'($urandom);
            rq.free_addr = ADDR_W'($urandom);
            pick = $urandom_range(99);
            if ($urandom_range(99) < (used > 180 ? 70 : 40))
            begin
                rq.op = OP_FREE;
                if (pick < 75 && bases.size() > 0)
                    rq.free_addr = ADDR_W'(bases[$urandom_range(bases.size() - 1)] * PAGE_BYTES);
                else if (pick < 83)
                    ;   // keep the random address
                else if (pick < 90)
                    rq.free_addr = ADDR_W'($urandom_range(NUM_PAGES - 1) * PAGE_BYTES);
                else if (pick < 95)
                    rq.free_addr = '0;
                else if (bases.size() > 0)
                    rq.free_addr = ADDR_W'(bases[$urandom_range(bases.size() - 1)] * PAGE_BYTES
                                           + $urandom_range(1, PAGE_BYTES - 1));
                else
                    rq.free_addr = rq.free_addr | 16'h0001;
            end
            else
            begin
                rq.op = OP_ALLOC;
                if (pick < 3)
                    rq.req_bytes = '0;
                else if (pick < 8)
                    ;   // keep the random size, mostly too large
                else if (pick < 14)
                    rq.req_bytes = ADDR_W'($urandom_range(1, 16) * PAGE_BYTES);
                else
                    rq.req_bytes = ADDR_W'($urandom_range(1, 4096));
            end
            send_request(rq);
        end
    endtask

    // Receiver holds off while requests keep coming, so the block must stall its input
    task automatic test_output_backpressure();
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_hold_request = HOLD_CYCLES;
        repeat (15)
        begin
            send_alloc(ADDR_W'($urandom_range(1, 1024)));
            send_free(ADDR_W'($urandom_range(1, 40) * PAGE_BYTES));
        end
        wait_drained();
    endtask

    // Result checker and receiver ready
    initial
    begin : response_checker
        outcome_t want;
        int       hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (queued_outcomes.size() == 0)
                begin
                    $display("%0t: unrequested result, expected none, actual %0h/%0h/%0h",
                             $time, rsp_ch.status, rsp_ch.alloc_addr, rsp_ch.freed_bytes);
                    mismatch_count++;
                end
                else
                begin
                    want = queued_outcomes.pop_front();
                    check_field("status", ADDR_W'(want.status), ADDR_W'(rsp_ch.status));
                    check_field("alloc_addr", want.alloc_addr, rsp_ch.alloc_addr);
                    check_field("freed_bytes", want.freed_bytes, rsp_ch.freed_bytes);
                end
            end
            if (rx_hold_request > 0)
            begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: cycles without any transaction on either side
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Test sequence
    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.op        <= OP_ALLOC;
        req_ch.req_bytes <= '0;
        req_ch.free_addr <= '0;
        for (int p = 0; p < NUM_PAGES; p++)
            page_busy[p] = (p == 0);
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(620, 38, 80);
        test_random_traffic(620, 80, 38);
        test_random_traffic(620, 0, 0);
        test_output_backpressure();

        wait_drained();
        repeat (DRAIN_WAIT)
            @(posedge clk);

        $display("Ran %0d requests: %0d allocations granted, %0d refused;",
                 sent_count, allocs_granted, allocs_refused);
        $display("%0d frees done, %0d refused, with a %0d-cycle output hold under load",
                 frees_done, frees_refused, HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
